// File: src/stw_pkg.sv
// Package for the sleep table tick waker.
// Holds the controller state type, result codes and the command and status
// structs that join the controller to the datapath. No dependencies.
package stw_pkg;

  // Result status codes as they appear on the output channel
  typedef enum logic [1:0] {
    STAT_WOKEN  = 2'd0,
    STAT_ACCEPT = 2'd1,
    STAT_ZERO   = 2'd2,
    STAT_FULL   = 2'd3
  } stat_code_t;

  // Operation codes of the input channel
  typedef enum logic {
    OP_SLEEP = 1'b0,
    OP_TICK  = 1'b1
  } op_code_t;

  // Which result the output register loads
  typedef enum logic [2:0] {
    RES_WOKEN_MID,
    RES_WOKEN_LAST,
    RES_ACCEPT,
    RES_ZERO,
    RES_FULL
  } res_sel_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_INS,
    S_TK_RD,
    S_TK_EV,
    S_TK_END,
    S_REPLY_OK,
    S_REPLY_ZERO,
    S_REPLY_FULL
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     in_ready;
    logic     take;
    logic     sel_tick;
    logic     sh_init;
    logic     sh_write;
    logic     ins_write;
    logic     tk_init;
    logic     tk_keep;
    logic     tk_wake;
    logic     tk_end;
    logic     emit;
    res_sel_t emit_sel;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_tick;
    logic zero_ticks;
    logic full;
    logic idx_zero;
    logic rd_done;
    logic expired;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

// File: src/stw_in_if.sv
// Input channel of the sleep table tick waker: valid/ready plus request fields.
// No dependencies.
interface stw_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  thread_id;
  logic [31:0] sleep_ticks;

  modport source (output valid, op, thread_id, sleep_ticks, input ready);
  modport sink   (input valid, op, thread_id, sleep_ticks, output ready);
endinterface

// File: src/stw_out_if.sv
// Output channel of the sleep table tick waker: valid/ready plus result fields.
// No dependencies.
interface stw_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] woken_id;
  logic       last;

  modport source (output valid, status, woken_id, last, input ready);
  modport sink   (input valid, status, woken_id, last, output ready);
endinterface

// File: src/stw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stw_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/stw_ctrl.sv
// Controller of the sleep table tick waker: sequences insertion shifts,
// tick scans and result emission. Depends on stw_pkg.
module stw_ctrl
  import stw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.is_tick)         state_next = S_TK_RD;
        else if (sts.zero_ticks) state_next = S_REPLY_ZERO;
        else if (sts.full)       state_next = S_REPLY_FULL;
        else                     state_next = S_SH_RD;
      end
      S_SH_RD: begin
        state_next = sts.idx_zero ? S_INS : S_SH_WR;
      end
      S_SH_WR: state_next = S_SH_RD;
      S_INS:   state_next = S_REPLY_OK;
      S_TK_RD: begin
        state_next = sts.rd_done ? S_TK_END : S_TK_EV;
      end
      S_TK_EV: begin
        if (!sts.expired || !sts.pend_valid || sts.out_free) state_next = S_TK_RD;
      end
      S_TK_END: begin
        if (!sts.pend_valid || sts.out_free) state_next = S_IDLE;
      end
      S_REPLY_OK, S_REPLY_ZERO, S_REPLY_FULL: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    cmd.emit_sel = RES_ACCEPT;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.take     = in_valid;
      end
      S_DECIDE: begin
        cmd.tk_init  = sts.is_tick;
        cmd.sh_init  = !sts.is_tick && !sts.zero_ticks && !sts.full;
        cmd.sel_tick = sts.is_tick;
      end
      S_SH_RD: cmd.sel_tick = 1'b0;
      S_SH_WR: cmd.sh_write = 1'b1;
      S_INS:   cmd.ins_write = 1'b1;
      S_TK_RD: cmd.sel_tick = 1'b1;
      S_TK_EV: begin
        cmd.sel_tick = 1'b1;
        cmd.emit_sel = RES_WOKEN_MID;
        if (!sts.expired) begin
          cmd.tk_keep = 1'b1;
        end else if (!sts.pend_valid) begin
          cmd.tk_wake = 1'b1;
        end else if (sts.out_free) begin
          cmd.tk_wake = 1'b1;
          cmd.emit    = 1'b1;
        end
      end
      S_TK_END: begin
        cmd.tk_end   = 1'b1;
        cmd.emit_sel = RES_WOKEN_LAST;
        cmd.emit     = sts.pend_valid && sts.out_free;
      end
      S_REPLY_OK: begin
        cmd.emit_sel = RES_ACCEPT;
        cmd.emit     = sts.out_free;
      end
      S_REPLY_ZERO: begin
        cmd.emit_sel = RES_ZERO;
        cmd.emit     = sts.out_free;
      end
      S_REPLY_FULL: begin
        cmd.emit_sel = RES_FULL;
        cmd.emit     = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: src/stw_dp.sv
// Datapath of the sleep table tick waker: entry RAM, fill count, scan
// pointers, pending woken id and output register. Depends on stw_pkg, stw_ram.
module stw_dp
  import stw_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int ID_BITS   = 8,
  parameter int TICK_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        in_op,
  input  logic [7:0]  in_thread_id,
  input  logic [31:0] in_sleep_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_woken_id,
  output logic        out_last
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = ID_BITS + TICK_BITS;

  // Latched request
  logic                 op_q;
  logic [ID_BITS-1:0]   id_q;
  logic [TICK_BITS-1:0] ticks_q;

  // Fill count and scan pointers
  logic [CW-1:0] occ;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] rd;
  logic [CW-1:0] wr;

  // Pending woken id, held until the next one or the scan end shows if it is last
  logic [ID_BITS-1:0] pend_id;
  logic               pend_valid;

  // RAM ports
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [EW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [EW-1:0]        ram_rdata;
  logic [ID_BITS-1:0]   rd_id;
  logic [TICK_BITS-1:0] rd_ticks;
  logic [TICK_BITS-1:0] dec_ticks;

  // Width adaptation of the request and result fields
  logic [ID_BITS+7:0]    id_ext;
  logic [TICK_BITS+31:0] ticks_ext;
  logic [ID_BITS+7:0]    wid_ext;
  logic                  out_free;

  assign id_ext    = {{ID_BITS{1'b0}}, in_thread_id};
  assign ticks_ext = {{TICK_BITS{1'b0}}, in_sleep_ticks};
  assign wid_ext   = {8'b0, pend_id};

  assign rd_id     = ram_rdata[EW-1:TICK_BITS];
  assign rd_ticks  = ram_rdata[TICK_BITS-1:0];
  assign dec_ticks = rd_ticks - TICK_BITS'(1);
  assign idx_m1    = idx - CW'(1);
  assign out_free  = !out_valid || out_ready;

  // Latch the request on acceptance
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q    <= in_op;
      id_q    <= id_ext[ID_BITS-1:0];
      ticks_q <= ticks_ext[TICK_BITS-1:0];
    end
  end

  // Select RAM addresses and write data
  always_comb begin
    ram_raddr = cmd.sel_tick ? rd[AW-1:0] : idx_m1[AW-1:0];
    ram_we    = cmd.sh_write || cmd.ins_write || cmd.tk_keep;
    ram_waddr = idx[AW-1:0];
    ram_wdata = ram_rdata;
    if (cmd.ins_write) begin
      ram_waddr = '0;
      ram_wdata = {id_q, ticks_q};
    end else if (cmd.tk_keep) begin
      ram_waddr = wr[AW-1:0];
      ram_wdata = {rd_id, dec_ticks};
    end
  end

  stw_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Advance fill count, pointers and pending id
  always_ff @(posedge clk) begin
    if (rst) begin
      occ        <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.ins_write) occ <= occ + CW'(1);
      if (cmd.tk_end)    occ <= wr;
      if (cmd.tk_init) begin
        pend_valid <= 1'b0;
      end else if (cmd.tk_wake) begin
        pend_valid <= 1'b1;
      end else if (cmd.emit && cmd.emit_sel == RES_WOKEN_LAST) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sh_init) idx <= occ;
    if (cmd.sh_write) idx <= idx_m1;
    if (cmd.tk_init) begin
      rd <= '0;
      wr <= '0;
    end else begin
      if (cmd.tk_keep || cmd.tk_wake) rd <= rd + CW'(1);
      if (cmd.tk_keep) wr <= wr + CW'(1);
    end
    if (cmd.tk_wake) pend_id <= rd_id;
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_sel)
        RES_WOKEN_MID: begin
          out_status   <= STAT_WOKEN;
          out_woken_id <= wid_ext[7:0];
          out_last     <= 1'b0;
        end
        RES_WOKEN_LAST: begin
          out_status   <= STAT_WOKEN;
          out_woken_id <= wid_ext[7:0];
          out_last     <= 1'b1;
        end
        RES_ZERO: begin
          out_status   <= STAT_ZERO;
          out_woken_id <= '0;
          out_last     <= 1'b1;
        end
        RES_FULL: begin
          out_status   <= STAT_FULL;
          out_woken_id <= '0;
          out_last     <= 1'b1;
        end
        default: begin
          out_status   <= STAT_ACCEPT;
          out_woken_id <= '0;
          out_last     <= 1'b1;
        end
      endcase
    end
  end

  // Status to the controller
  always_comb begin
    sts.is_tick    = (op_q == OP_TICK);
    sts.zero_ticks = (ticks_q == '0);
    sts.full       = (occ == CW'(SLOTS));
    sts.idx_zero   = (idx == '0);
    sts.rd_done    = (rd == occ);
    sts.expired    = (dec_ticks == '0);
    sts.pend_valid = pend_valid;
    sts.out_free   = out_free;
  end

endmodule

// File: src/sleep_table_tick_waker.sv
// Top level of the sleep table tick waker: joins controller and datapath to
// the two channels. Depends on stw_pkg, stw_in_if, stw_out_if, stw_ctrl, stw_dp.
//
// Keeps up to SLOTS sleeping threads, newest first, in a single-port-write
// RAM. A sleep request with nonzero ticks shifts the table down one entry at a
// time and inserts at the head, answering status 1; zero ticks answers 2 and a
// full table answers 3. A tick scans every entry once, decrements it and
// compacts the survivors in place; each expired id comes out newest first,
// the final one marked last, and a tick that wakes nobody gives no result.
// A tick passes every entry held through the RAM read port once and each
// survivor through the write port; an accepted sleep passes every entry
// through both ports once, while a zero-time or full-table sleep touches no
// entry. An output stall holds the scan or reply until the output register
// is free. A new request is taken only once the previous one is finished,
// while its last result may still be waiting in the output register.
module sleep_table_tick_waker
  import stw_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int ID_BITS   = 8,
  parameter int TICK_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  stw_in_if.sink    in_ch,
  stw_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  assign in_ch.ready = cmd.in_ready;

  stw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  stw_dp #(
    .SLOTS     (SLOTS),
    .ID_BITS   (ID_BITS),
    .TICK_BITS (TICK_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_ch.op),
    .in_thread_id   (in_ch.thread_id),
    .in_sleep_ticks (in_ch.sleep_ticks),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_status     (out_ch.status),
    .out_woken_id   (out_ch.woken_id),
    .out_last       (out_ch.last)
  );

endmodule
